>>> src/fnmf_pkg.sv
// ----------------------------------------------------------------------------
// fnmf_pkg
// Shared widths, register codes and the item record handed from the line
// front end to the result stage of the four-neighbor max filter.
// ----------------------------------------------------------------------------
package fnmf_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int POS_W     = 16;
  localparam int OUT_POS_W = 10;
  localparam int APB_W     = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_SEL   = 2;
  localparam int LINE_W    = 2 * PIX_W;

  typedef enum logic [0:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] l1;
    logic [PIX_W-1:0] l2;
  } line_entry_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] up_l1;
    logic [PIX_W-1:0] up_l2;
    logic [PIX_W-1:0] up_left;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] left_left;
    logic             row_ge1;
    logic             row_ge2;
    logic             col_ge1;
    logic             col_ge2;
    logic             last_row;
    logic             last_col;
  } pix_t;

endpackage

>>> src/four_neighbor_max_filter.sv
// ----------------------------------------------------------------------------
// four_neighbor_max_filter
// Results: an accepted item is held in the result stage, from which its results
//   go to the output register one per cycle while the output does not stall.
// Throughput: one pixel per cycle while each causes at most one result and the
//   output does not stall; a pixel that causes two or three results (last row)
//   holds the input until the single output register has taken all of them.
// Reset: position, flags and sizes (4 rows by 5 columns) clear at once; the
//   line RAM is not cleared; data read before it is written is masked by the flags.
// ----------------------------------------------------------------------------
module four_neighbor_max_filter #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fnmf_pkg::ADDR_W-1:0]     paddr,
  input  logic [fnmf_pkg::APB_W-1:0]      pwdata,
  output logic [fnmf_pkg::APB_W-1:0]      prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fnmf_pkg::PIX_W-1:0]      pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fnmf_pkg::OUT_POS_W-1:0]  out_row,
  output logic [fnmf_pkg::OUT_POS_W-1:0]  out_col,
  output logic [fnmf_pkg::PIX_W-1:0]      max_value,
  output logic                            has_neighbor,
  output logic                            frame_end,
  output logic                            run_last
);
  import fnmf_pkg::*;

  logic [CFG_W-1:0] rows_eff;
  logic [CFG_W-1:0] cols_eff;
  logic             restart;
  logic             take_ok;
  logic             pix_load;
  pix_t             pix;
  logic [PIX_W-1:0] ahead;

  fnmf_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .rows_eff (rows_eff),
    .cols_eff (cols_eff),
    .restart  (restart)
  );

  fnmf_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .rows_eff (rows_eff),
    .cols_eff (cols_eff),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pixel    (pixel),
    .take_ok  (take_ok),
    .pix_load (pix_load),
    .pix      (pix),
    .ahead    (ahead)
  );

  fnmf_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .pix_load     (pix_load),
    .pix          (pix),
    .ahead        (ahead),
    .take_ok      (take_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row      (out_row),
    .out_col      (out_col),
    .max_value    (max_value),
    .has_neighbor (has_neighbor),
    .frame_end    (frame_end),
    .run_last     (run_last)
  );

endmodule

>>> src/fnmf_ram.sv
// ----------------------------------------------------------------------------
// fnmf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fnmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/fnmf_cfg.sv
// ----------------------------------------------------------------------------
// fnmf_cfg
// Frame size registers on the APB port, with the clamped sizes in use.
// ----------------------------------------------------------------------------
module fnmf_cfg #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fnmf_pkg::ADDR_W-1:0]   paddr,
  input  logic [fnmf_pkg::APB_W-1:0]    pwdata,
  output logic [fnmf_pkg::APB_W-1:0]    prdata,
  output logic                          pready,
  output logic [fnmf_pkg::CFG_W-1:0]    rows_eff,
  output logic [fnmf_pkg::CFG_W-1:0]    cols_eff,
  output logic                          restart
);
  import fnmf_pkg::*;

  localparam int CFG_MAX = (1 << CFG_W) - 1;
  localparam int ROW_LIM = (MAX_ROWS < CFG_MAX) ? MAX_ROWS : CFG_MAX;
  localparam int COL_LIM = (MAX_COLS < CFG_MAX) ? MAX_COLS : CFG_MAX;

  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] col_count;
  reg_idx_t         idx;
  logic             wr;

  assign pready  = 1'b1;
  assign idx     = reg_idx_t'(paddr[REG_SEL]);
  assign wr      = psel && penable && pwrite;
  assign restart = wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CFG_W'(4);
      col_count <= CFG_W'(5);
    end else if (wr) begin
      case (idx)
        REG_ROW_COUNT: row_count <= pwdata[CFG_W-1:0];
        REG_COL_COUNT: col_count <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROW_COUNT: prdata = APB_W'(row_count);
      REG_COL_COUNT: prdata = APB_W'(col_count);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    if (row_count == '0) begin
      rows_eff = CFG_W'(1);
    end else if (row_count > CFG_W'(ROW_LIM)) begin
      rows_eff = CFG_W'(ROW_LIM);
    end else begin
      rows_eff = row_count;
    end
    if (col_count == '0) begin
      cols_eff = CFG_W'(1);
    end else if (col_count > CFG_W'(COL_LIM)) begin
      cols_eff = CFG_W'(COL_LIM);
    end else begin
      cols_eff = col_count;
    end
  end

endmodule

>>> src/fnmf_front.sv
// ----------------------------------------------------------------------------
// fnmf_front
// Input side: raster position, line store read-modify-write with one-ahead
// prefetch, and the record of neighbor values for each item.
// ----------------------------------------------------------------------------
module fnmf_front #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        restart,
  input  logic [fnmf_pkg::CFG_W-1:0]  rows_eff,
  input  logic [fnmf_pkg::CFG_W-1:0]  cols_eff,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fnmf_pkg::PIX_W-1:0]  pixel,
  input  logic                        take_ok,
  output logic                        pix_load,
  output fnmf_pkg::pix_t              pix,
  output logic [fnmf_pkg::PIX_W-1:0]  ahead
);
  import fnmf_pkg::*;

  localparam int CPW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RPW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CMP_W = POS_W + 1;

  logic [RPW-1:0]    row_pos;
  logic [CPW-1:0]    col_pos;
  logic [CPW-1:0]    nxt_col;
  logic [PIX_W-1:0]  left_pixel;
  logic [PIX_W-1:0]  left_left_pixel;
  logic [PIX_W-1:0]  up_left;
  logic              fwd;
  line_entry_t       fwd_data;
  logic [LINE_W-1:0] ram_q;
  line_entry_t       entry_now;
  line_entry_t       wr_entry;
  logic [CMP_W-1:0]  row_ext;
  logic [CMP_W-1:0]  col_ext;
  logic              last_row;
  logic              last_col;
  logic              take;

  assign take     = in_valid && take_ok;
  assign in_stall = !take_ok;
  assign pix_load = take;

  assign row_ext  = CMP_W'(row_pos);
  assign col_ext  = CMP_W'(col_pos);
  assign last_row = (row_ext + CMP_W'(1)) == CMP_W'(rows_eff);
  assign last_col = (col_ext + CMP_W'(1)) == CMP_W'(cols_eff);
  assign nxt_col  = last_col ? '0 : col_pos + CPW'(1);

  assign entry_now   = fwd ? fwd_data : line_entry_t'(ram_q);
  assign wr_entry.l1 = pixel;
  assign wr_entry.l2 = entry_now.l1;
  assign ahead       = entry_now.l1;

  fnmf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (take),
    .wr_addr (col_pos),
    .wr_data (wr_entry),
    .rd_en   (take),
    .rd_addr (nxt_col),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos         <= '0;
      col_pos         <= '0;
      left_pixel      <= '0;
      left_left_pixel <= '0;
      fwd             <= 1'b0;
    end else if (restart) begin
      row_pos         <= '0;
      col_pos         <= '0;
      left_pixel      <= '0;
      left_left_pixel <= '0;
    end else if (take) begin
      left_pixel      <= pixel;
      left_left_pixel <= left_pixel;
      fwd             <= (nxt_col == col_pos);
      col_pos         <= nxt_col;
      if (last_col) begin
        row_pos <= last_row ? '0 : row_pos + RPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fwd_data <= wr_entry;
      up_left  <= entry_now.l1;
    end
  end

  always_comb begin
    pix.pixel     = pixel;
    pix.row       = POS_W'(row_pos);
    pix.col       = POS_W'(col_pos);
    pix.up_l1     = entry_now.l1;
    pix.up_l2     = entry_now.l2;
    pix.up_left   = up_left;
    pix.left      = left_pixel;
    pix.left_left = left_left_pixel;
    pix.row_ge1   = row_ext >= CMP_W'(1);
    pix.row_ge2   = row_ext >= CMP_W'(2);
    pix.col_ge1   = col_ext >= CMP_W'(1);
    pix.col_ge2   = col_ext >= CMP_W'(2);
    pix.last_row  = last_row;
    pix.last_col  = last_col;
  end

endmodule

>>> src/fnmf_emit.sv
// ----------------------------------------------------------------------------
// fnmf_emit
// Result stage: holds one item, works out its up to three results and hands
// them one per cycle to the output register while the output does not stall.
// ----------------------------------------------------------------------------
module fnmf_emit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pix_load,
  input  fnmf_pkg::pix_t                  pix,
  input  logic [fnmf_pkg::PIX_W-1:0]      ahead,
  output logic                            take_ok,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fnmf_pkg::OUT_POS_W-1:0]  out_row,
  output logic [fnmf_pkg::OUT_POS_W-1:0]  out_col,
  output logic [fnmf_pkg::PIX_W-1:0]      max_value,
  output logic                            has_neighbor,
  output logic                            frame_end,
  output logic                            run_last
);
  import fnmf_pkg::*;

  localparam logic [2:0] RES_UP  = 3'b001;
  localparam logic [2:0] RES_ROW = 3'b010;
  localparam logic [2:0] RES_END = 3'b100;

  function automatic logic [PIX_W-1:0] max8(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    max8 = (a > b) ? a : b;
  endfunction

  pix_t                 cur;
  logic [2:0]           pend;
  logic [2:0]           pend_new;
  logic [2:0]           sel;
  logic [2:0]           pend_rest;
  logic                 slot_free;
  logic                 issue;
  logic [PIX_W-1:0]     up_best;
  logic [PIX_W-1:0]     row_best;
  logic [PIX_W-1:0]     end_best;
  logic [POS_W-1:0]     res_row;
  logic [POS_W-1:0]     res_col;
  logic [PIX_W-1:0]     res_max;
  logic                 res_has;
  logic                 res_end;

  assign pend_new  = {pix.last_row && pix.last_col,
                      pix.last_row && pix.col_ge1,
                      pix.row_ge1};
  assign sel       = pend & (~pend + 3'd1);
  assign pend_rest = pend & ~sel;
  assign slot_free = !out_valid || !out_stall;
  assign issue     = (pend != '0) && slot_free;
  assign take_ok   = (pend == '0) || (issue && (pend_rest == '0));

  assign up_best  = max8(max8(cur.pixel, cur.row_ge2 ? cur.up_l2 : '0),
                         max8(cur.col_ge1 ? cur.up_left : '0,
                              cur.last_col ? '0 : ahead));
  assign row_best = max8(cur.pixel,
                         max8(cur.row_ge1 ? cur.up_left : '0,
                              cur.col_ge2 ? cur.left_left : '0));
  assign end_best = max8(cur.row_ge1 ? cur.up_l1 : '0,
                         cur.col_ge1 ? cur.left : '0);

  always_comb begin
    case (sel)
      RES_UP: begin
        res_row = cur.row - POS_W'(1);
        res_col = cur.col;
        res_max = up_best;
        res_has = 1'b1;
        res_end = 1'b0;
      end
      RES_ROW: begin
        res_row = cur.row;
        res_col = cur.col - POS_W'(1);
        res_max = row_best;
        res_has = 1'b1;
        res_end = 1'b0;
      end
      RES_END: begin
        res_row = cur.row;
        res_col = cur.col;
        res_max = end_best;
        res_has = cur.row_ge1 || cur.col_ge1;
        res_end = 1'b1;
      end
      default: begin
        res_row = '0;
        res_col = '0;
        res_max = '0;
        res_has = 1'b0;
        res_end = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (pix_load) begin
      pend <= pend_new;
    end else if (issue) begin
      pend <= pend_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_load) begin
      cur <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_row      <= OUT_POS_W'(res_row);
      out_col      <= OUT_POS_W'(res_col);
      max_value    <= res_max;
      has_neighbor <= res_has;
      frame_end    <= res_end;
      run_last     <= (pend_rest == '0);
    end
  end

endmodule
